### rtl/panel_switch_debounce_dispatch_macros.svh
// ----------------------------------------------------------------------------
// Panel switch dispatch assertion macros
// Shared concurrent assertion forms for the port monitor.
// ----------------------------------------------------------------------------
`ifndef PANEL_SWITCH_DEBOUNCE_DISPATCH_MACROS_SVH
`define PANEL_SWITCH_DEBOUNCE_DISPATCH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSDD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psdd: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSDD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psdd: assertion failed");

`endif

### rtl/psdd_pkg.sv
// ----------------------------------------------------------------------------
// Panel switch dispatch package
// Shared constants, key slot indexes and key status type.
// ----------------------------------------------------------------------------
package psdd_pkg;

  localparam int unsigned NKEYS        = 12;
  localparam int unsigned SETTLE_SCANS = 8;
  localparam int unsigned REPEAT_SCALE = 16;
  localparam int unsigned CNT_W        = 4;
  localparam int unsigned RPT_W        = 9;
  localparam int unsigned RATE_W       = 4;
  localparam int unsigned ADDR_W       = 18;
  localparam int unsigned DEV_W        = 9;
  localparam int unsigned ROW_W        = 16;
  localparam int unsigned MODE_W       = 10;
  // Repeat reload product width: (rate + 1) * REPEAT_SCALE
  localparam int unsigned PROD_W       = RATE_W + 1 + $clog2(REPEAT_SCALE + 1);

  localparam logic [CNT_W-1:0]  SETTLE_LOAD = CNT_W'(SETTLE_SCANS & 'hF);
  localparam logic [ADDR_W-1:0] DEV_MASK    = ADDR_W'('o774);
  localparam logic [RPT_W-1:0]  RPT_MAX     = '1;

  // Key slots
  localparam int unsigned K_EXAM_THIS = 1;
  localparam int unsigned K_EXECUTE   = 2;
  localparam int unsigned K_RESET     = 3;
  localparam int unsigned K_STOP      = 4;
  localparam int unsigned K_CONTINUE  = 5;
  localparam int unsigned K_READIN    = 7;
  localparam int unsigned K_DEP_NEXT  = 10;
  localparam int unsigned K_DEP_THIS  = 11;

  // Row 2 control bits
  localparam int unsigned R2_REPEAT = 5;
  localparam int unsigned R2_MAINT  = 7;

  typedef logic [NKEYS-1:0] key_vec_t;

  // Debounced key status handed from the filter to the dispatcher
  typedef struct packed {
    key_vec_t level;
    key_vec_t pending;
  } key_stat_t;

endpackage

### rtl/psdd_debounce.sv
// ----------------------------------------------------------------------------
// Panel switch debounce filter
// Per-key settle counters; reports new levels and armed edge events.
// ----------------------------------------------------------------------------
module psdd_debounce (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              scan_en,
  input  psdd_pkg::key_vec_t raw_keys,
  input  psdd_pkg::key_vec_t pending_in,
  output psdd_pkg::key_stat_t stat
);
  import psdd_pkg::*;

  key_vec_t         level_r, level_nxt;
  key_vec_t         last_r, last_nxt;
  logic [CNT_W-1:0] cnt_r [NKEYS];
  logic [CNT_W-1:0] cnt_nxt [NKEYS];

  always_comb begin
    level_nxt   = level_r;
    last_nxt    = last_r;
    stat.pending = pending_in;
    for (int k = 0; k < NKEYS; k++) begin
      cnt_nxt[k] = cnt_r[k];
      if (level_r[k] != raw_keys[k]) begin
        level_nxt[k]    = raw_keys[k];
        cnt_nxt[k]      = SETTLE_LOAD;
        stat.pending[k] = 1'b0;
      end else if (cnt_r[k] != '0) begin
        cnt_nxt[k] = cnt_r[k] - 1'b1;
      end else begin
        // settled: arm an event on a change of accepted level
        if (last_r[k] != level_r[k]) stat.pending[k] = 1'b1;
        last_nxt[k] = level_r[k];
      end
    end
    stat.level = level_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      last_r  <= '0;
      for (int k = 0; k < NKEYS; k++) cnt_r[k] <= '0;
    end else if (scan_en) begin
      level_r <= level_nxt;
      last_r  <= last_nxt;
      for (int k = 0; k < NKEYS; k++) cnt_r[k] <= cnt_nxt[k];
    end
  end

endmodule

### rtl/panel_switch_debounce_dispatch.sv
// Each accepted scan loads the result register and shows its result in the next cycle.
// One scan per cycle unless a result stalls; the key update: one shallow pass over 12 slots.
// in_ready is high whenever the result register is empty or being drained this cycle.
// Reset (rst_n low, synchronous): all key, repeat and latch state clears; no result pending.
// ----------------------------------------------------------------------------
// Panel switch debounce and dispatch
// Debounces front-panel keys, runs auto-repeat and turns key events into
// maintenance settings or run-time request pulses, one result per scan.
// ----------------------------------------------------------------------------
module panel_switch_debounce_dispatch (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [psdd_pkg::ROW_W-1:0]  in_row_two_bits,
  input  logic [psdd_pkg::ROW_W-1:0]  in_row_three_bits,
  input  logic [psdd_pkg::ROW_W-1:0]  in_row_four_bits,
  input  logic                        in_cpu_running,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_examine_pulse,
  output logic                        out_execute_pulse,
  output logic                        out_stop_pulse,
  output logic                        out_deposit_pulse,
  output logic                        out_power_off_pulse,
  output logic                        out_clear_indicator,
  output logic [psdd_pkg::ADDR_W-1:0] out_address_latched,
  output logic [psdd_pkg::DEV_W-1:0]  out_readin_device,
  output logic [psdd_pkg::RATE_W-1:0] out_repeat_rate,
  output logic                        out_indicator_disabled,
  output logic [psdd_pkg::NKEYS-1:0]  out_pending_keys,
  output logic [psdd_pkg::MODE_W-1:0] out_mode_bits
);
  import psdd_pkg::*;

  // ---- handshake -----------------------------------------------------------
  logic scan_en;
  logic out_valid_r;

  assign in_ready = !out_valid_r || out_ready;
  assign scan_en  = in_valid && in_ready;

  // ---- persistent state ----------------------------------------------------
  key_vec_t          pending_r, pending_nxt;
  logic [RPT_W-1:0]  rpt_r, rpt_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic              ind_off_r, ind_off_nxt;
  logic [DEV_W-1:0]  dev_r, dev_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;

  // Keys 0-7 come from row 4, deposit keys from row 2; slots 8 and 9 are
  // never wired and simply stay idle.
  key_vec_t  raw_keys;
  key_stat_t kstat;

  assign raw_keys = {in_row_two_bits[11:10], 2'b00, in_row_four_bits[7:0]};

  psdd_debounce u_debounce (
    .clk        (clk),
    .rst_n      (rst_n),
    .scan_en    (scan_en),
    .raw_keys   (raw_keys),
    .pending_in (pending_r),
    .stat       (kstat)
  );

  // ---- dispatch ------------------------------------------------------------
  logic              maint, repeat_on;
  logic [ADDR_W-1:0] addr_in;
  key_vec_t          maint_hit, pend_m, pend_r2, run_hit;
  logic [RPT_W-1:0]  rpt_dec;
  logic [PROD_W-1:0] reload_wide;
  logic              exam_p, exec_p, stop_p, dep_p, pwr_p, clr_p;

  assign maint     = in_row_two_bits[R2_MAINT];
  assign repeat_on = in_row_two_bits[R2_REPEAT];
  // Row 4 address bits sit in the top two bits of the word
  assign addr_in   = {in_row_three_bits, in_row_four_bits[15:14]};

  always_comb begin
    rate_nxt    = rate_r;
    ind_off_nxt = ind_off_r;
    dev_nxt     = dev_r;
    addr_nxt    = addr_r;
    exam_p      = 1'b0;
    exec_p      = 1'b0;
    stop_p      = 1'b0;
    dep_p       = 1'b0;
    pwr_p       = 1'b0;
    clr_p       = 1'b0;

    // Maintenance mode: events become settings, every hit key is consumed
    maint_hit = maint ? (kstat.pending & kstat.level) : '0;
    pend_m    = kstat.pending & ~maint_hit;
    if (maint_hit[K_READIN]) dev_nxt = DEV_W'(addr_in & DEV_MASK);
    if (maint_hit[K_CONTINUE]) begin
      ind_off_nxt = !ind_off_r;
      if (!ind_off_r) clr_p = 1'b1;
    end
    if (maint_hit[K_STOP]) begin
      stop_p = 1'b1;
      pwr_p  = 1'b1;
    end
    if (maint_hit[K_EXAM_THIS]) rate_nxt = addr_in[ADDR_W-1 -: RATE_W];
    if (!maint) addr_nxt = addr_in;

    // Auto-repeat: on expiry every key re-arms from its level
    rpt_dec = rpt_r;
    pend_r2 = pend_m;
    if (rpt_r != '0) begin
      rpt_dec = rpt_r - 1'b1;
      if (rpt_dec == '0) pend_r2 = kstat.level;
    end

    // Running: request pulses; reset key stays armed so stop repeats
    run_hit     = in_cpu_running ? (pend_r2 & kstat.level) : '0;
    reload_wide = PROD_W'({1'b0, rate_nxt} + 1'b1) * PROD_W'(REPEAT_SCALE);
    rpt_nxt     = rpt_dec;
    if ((run_hit != '0) && repeat_on) begin
      rpt_nxt = (reload_wide > PROD_W'(RPT_MAX)) ? RPT_MAX : RPT_W'(reload_wide);
    end
    if (run_hit[K_EXAM_THIS]) begin
      exam_p = 1'b1;
      clr_p  = 1'b1;
    end
    if (run_hit[K_EXECUTE]) exec_p = 1'b1;
    if (run_hit[K_RESET] || run_hit[K_STOP]) stop_p = 1'b1;
    if (run_hit[K_DEP_THIS]) begin
      dep_p = 1'b1;
      clr_p = 1'b1;
    end
    pending_nxt            = pend_r2 & ~run_hit;
    pending_nxt[K_RESET]   = pend_r2[K_RESET];
  end

  // ---- state registers -----------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      rpt_r     <= '0;
      rate_r    <= '0;
      ind_off_r <= 1'b0;
      dev_r     <= '0;
      addr_r    <= '0;
    end else if (scan_en) begin
      pending_r <= pending_nxt;
      rpt_r     <= rpt_nxt;
      rate_r    <= rate_nxt;
      ind_off_r <= ind_off_nxt;
      dev_r     <= dev_nxt;
      addr_r    <= addr_nxt;
    end
  end

  // ---- result register -----------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (scan_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload needs no reset; it loads with each accepted transaction
  always_ff @(posedge clk) begin
    if (scan_en) begin
      out_examine_pulse      <= exam_p;
      out_execute_pulse      <= exec_p;
      out_stop_pulse         <= stop_p;
      out_deposit_pulse      <= dep_p;
      out_power_off_pulse    <= pwr_p;
      out_clear_indicator    <= clr_p;
      out_address_latched    <= addr_nxt;
      out_readin_device      <= dev_nxt;
      out_repeat_rate        <= rate_nxt;
      out_indicator_disabled <= ind_off_nxt;
      out_pending_keys       <= pending_nxt;
      out_mode_bits          <= in_row_two_bits[MODE_W-1:0];
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/psdd_port_monitor.sv
// ----------------------------------------------------------------------------
// Panel switch dispatch port monitor
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "panel_switch_debounce_dispatch_macros.svh"

module psdd_port_monitor (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_examine_pulse,
  input logic                        out_stop_pulse,
  input logic                        out_deposit_pulse,
  input logic                        out_power_off_pulse,
  input logic                        out_clear_indicator,
  input logic [psdd_pkg::DEV_W-1:0]  out_readin_device
);
  import psdd_pkg::*;

  // A stalled result holds its valid
  `PSDD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // No new transaction while a result waits
  `PSDD_ASSERT_NOW(a_in_blocked, out_valid && !out_ready, !in_ready)
  // Power-off always comes with stop
  `PSDD_ASSERT_NOW(a_pwr_stop, out_valid && out_power_off_pulse, out_stop_pulse)
  // Examine and deposit blank the indicator
  `PSDD_ASSERT_NOW(a_clr, out_valid && (out_examine_pulse || out_deposit_pulse), out_clear_indicator)
  // Boot device is word aligned
  `PSDD_ASSERT_NOW(a_dev_align, out_valid, out_readin_device[1:0] == 2'b00)

endmodule

bind panel_switch_debounce_dispatch psdd_port_monitor u_port_monitor (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_examine_pulse   (out_examine_pulse),
  .out_stop_pulse      (out_stop_pulse),
  .out_deposit_pulse   (out_deposit_pulse),
  .out_power_off_pulse (out_power_off_pulse),
  .out_clear_indicator (out_clear_indicator),
  .out_readin_device   (out_readin_device)
);

### dv/panel_switch_debounce_dispatch_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Panel switch debounce and dispatch testbench
// Sends front-panel scans through the valid/ready input and checks every
// result against an in-bench model of debounce, repeat and key dispatch.
// A short directed opening is followed by press/hold/release episodes with
// bounce and noise. Random stalls hit both sides, with one long stall on the
// result side.
// ----------------------------------------------------------------------------
module panel_switch_debounce_dispatch_tb;
  import psdd_pkg::*;

  localparam int unsigned QUIET_LIMIT   = 2000;  // cycles without any transaction
  localparam int unsigned SCAN_TARGET   = 950;
  localparam int unsigned TAIL_SCANS    = 100;   // no idling while this many remain
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned HOLD_OFF_AT   = 300;   // scans accepted before the long stall
  localparam int unsigned HOLD_OFF_LEN  = 60;
  localparam int unsigned DRAIN_CYCLES  = 4;

  // Slots 0-7 come from row 4, slots 10-11 from row 2; 8 and 9 never move.
  localparam key_vec_t SCANNED_KEYS = 12'hCFF;

  typedef struct packed {
    logic [ROW_W-1:0] row_two;
    logic [ROW_W-1:0] row_three;
    logic [ROW_W-1:0] row_four;
    logic             running;
  } panel_scan_t;

  typedef struct packed {
    logic              exam;
    logic              exec;
    logic              stop;
    logic              dep;
    logic              pwr;
    logic              clr;
    logic [ADDR_W-1:0] addr;
    logic [DEV_W-1:0]  dev;
    logic [RATE_W-1:0] rate;
    logic              ind_dis;
    key_vec_t          pend;
    logic [MODE_W-1:0] mode;
  } panel_out_t;

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  logic              in_valid          = 1'b0;
  logic              in_ready;
  logic [ROW_W-1:0]  in_row_two_bits   = '0;
  logic [ROW_W-1:0]  in_row_three_bits = '0;
  logic [ROW_W-1:0]  in_row_four_bits  = '0;
  logic              in_cpu_running    = 1'b0;
  logic              out_valid;
  logic              out_ready         = 1'b0;
  logic              out_examine_pulse;
  logic              out_execute_pulse;
  logic              out_stop_pulse;
  logic              out_deposit_pulse;
  logic              out_power_off_pulse;
  logic              out_clear_indicator;
  logic [ADDR_W-1:0] out_address_latched;
  logic [DEV_W-1:0]  out_readin_device;
  logic [RATE_W-1:0] out_repeat_rate;
  logic              out_indicator_disabled;
  key_vec_t          out_pending_keys;
  logic [MODE_W-1:0] out_mode_bits;

  panel_switch_debounce_dispatch dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_row_two_bits       (in_row_two_bits),
    .in_row_three_bits     (in_row_three_bits),
    .in_row_four_bits      (in_row_four_bits),
    .in_cpu_running        (in_cpu_running),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_examine_pulse     (out_examine_pulse),
    .out_execute_pulse     (out_execute_pulse),
    .out_stop_pulse        (out_stop_pulse),
    .out_deposit_pulse     (out_deposit_pulse),
    .out_power_off_pulse   (out_power_off_pulse),
    .out_clear_indicator   (out_clear_indicator),
    .out_address_latched   (out_address_latched),
    .out_readin_device     (out_readin_device),
    .out_repeat_rate       (out_repeat_rate),
    .out_indicator_disabled(out_indicator_disabled),
    .out_pending_keys      (out_pending_keys),
    .out_mode_bits         (out_mode_bits)
  );

  // --------------------------------------------------------------------------
  // Panel model state; all zero at reset, and reset happens once.
  // --------------------------------------------------------------------------
  key_vec_t          key_lvl  = '0;   // debounced level
  key_vec_t          key_last = '0;   // last level that settled
  key_vec_t          key_pend = '0;   // armed edge, not yet consumed
  logic [CNT_W-1:0]  key_settle [NKEYS];
  logic [RPT_W-1:0]  rpt_left = '0;
  logic [RATE_W-1:0] rate_sel = '0;
  logic              ind_off  = 1'b0;
  logic [DEV_W-1:0]  boot_dev = '0;
  logic [ADDR_W-1:0] addr_hold = '0;

  initial begin
    for (int k = 0; k < NKEYS; k++) key_settle[k] = '0;
  end

  panel_scan_t scans_to_send[$];
  panel_out_t  awaited_panel_outputs[$];

  int unsigned scans_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned fault_count    = 0;
  int unsigned send_gap       = 0;
  int unsigned sink_gap       = 0;
  logic        hold_off       = 1'b0;

  panel_scan_t accepted_scan;
  panel_scan_t next_scan;
  panel_out_t  seen_out;
  panel_out_t  want_out;

  // One scan through debounce, maintenance settings, repeat and run dispatch.
  function automatic panel_out_t debounce_and_dispatch(input panel_scan_t s);
    panel_out_t        r;
    key_vec_t          raw;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       reload;
    logic              repeat_on;
    r = '0;
    raw = '0;
    raw[7:0] = s.row_four[7:0];
    raw[K_DEP_NEXT] = s.row_two[K_DEP_NEXT];
    raw[K_DEP_THIS] = s.row_two[K_DEP_THIS];
    repeat_on = s.row_two[R2_REPEAT];

    for (int k = 0; k < NKEYS; k++) begin
      if (!SCANNED_KEYS[k]) continue;
      if (key_lvl[k] != raw[k]) begin
        key_lvl[k] = raw[k];
        key_settle[k] = SETTLE_LOAD;
        key_pend[k] = 1'b0;
      end else if (key_settle[k] != '0) begin
        key_settle[k] = key_settle[k] - 1'b1;
      end else begin
        if (key_last[k] != key_lvl[k]) key_pend[k] = 1'b1;
        key_last[k] = key_lvl[k];
      end
    end

    // row 4 bits 14-15 are the low two address bits
    addr = {s.row_three, s.row_four[15:14]};

    if (s.row_two[R2_MAINT]) begin
      for (int k = 0; k < NKEYS; k++) begin
        if (key_pend[k] && key_lvl[k]) begin
          key_pend[k] = 1'b0;
          case (k)
            K_READIN: boot_dev = DEV_W'(addr & DEV_MASK);
            K_CONTINUE: begin
              ind_off = ~ind_off;
              if (ind_off) r.clr = 1'b1;
            end
            K_STOP: begin
              r.stop = 1'b1;
              r.pwr = 1'b1;
            end
            K_EXAM_THIS: rate_sel = addr[17:14];
            default: ;
          endcase
        end
      end
    end else begin
      addr_hold = addr;
    end

    // countdown expiry re-arms every key still held
    if (rpt_left != '0) begin
      rpt_left = rpt_left - 1'b1;
      if (rpt_left == '0) key_pend = key_lvl;
    end

    if (s.running) begin
      for (int k = 0; k < NKEYS; k++) begin
        if (key_pend[k] && key_lvl[k]) begin
          if (repeat_on) begin
            reload = (32'(rate_sel) + 32'd1) * REPEAT_SCALE;
            rpt_left = (reload > 32'(RPT_MAX)) ? RPT_MAX : reload[RPT_W-1:0];
          end
          case (k)
            K_EXAM_THIS: begin
              r.exam = 1'b1;
              r.clr = 1'b1;
            end
            K_EXECUTE: r.exec = 1'b1;
            K_RESET, K_STOP: r.stop = 1'b1;
            K_DEP_THIS: begin
              r.dep = 1'b1;
              r.clr = 1'b1;
            end
            default: ;
          endcase
          // reset key stays armed, so stop repeats while it is held
          if (k != K_RESET) key_pend[k] = 1'b0;
        end
      end
    end

    r.addr = addr_hold;
    r.dev = boot_dev;
    r.rate = rate_sel;
    r.ind_dis = ind_off;
    r.pend = key_pend;
    r.mode = s.row_two[MODE_W-1:0];
    return r;
  endfunction

  function automatic string show_panel(input panel_out_t v);
    return $sformatf({"exam=%0b exec=%0b stop=%0b dep=%0b pwr=%0b clr=%0b addr=%05h",
                      " dev=%03o rate=%0d ind_dis=%0b pend=%03h mode=%03h"},
                     v.exam, v.exec, v.stop, v.dep, v.pwr, v.clr, v.addr,
                     v.dev, v.rate, v.ind_dis, v.pend, v.mode);
  endfunction

  // Idling is off during the long stall, in every third window and in the tail.
  function automatic logic idling_allowed();
    return !hold_off && scans_to_send.size() > TAIL_SCANS
           && ((scans_accepted / 90) % 3 != 2);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_scan(input logic [ROW_W-1:0] r2, input logic [ROW_W-1:0] r3,
                            input logic [ROW_W-1:0] r4, input logic run);
    panel_scan_t s;
    s.row_two = r2;
    s.row_three = r3;
    s.row_four = r4;
    s.running = run;
    scans_to_send.push_back(s);
  endtask

  // Row 3 top nibble feeds the repeat rate; keep it low half the time so the
  // countdown expires within an episode.
  function automatic logic [ROW_W-1:0] pick_row_three();
    logic [ROW_W-1:0] v;
    v = ROW_W'($urandom);
    if ($urandom_range(0, 1) != 0) v[15:12] = 4'($urandom_range(0, 1));
    return v;
  endfunction

  // One key episode: press (with optional bounce), hold, then release.
  task automatic add_press_episode();
    key_vec_t         press;
    key_vec_t         keys;
    logic             maint;
    logic             rpt;
    logic             run;
    logic [ROW_W-1:0] r2;
    logic [ROW_W-1:0] r4;
    int unsigned      slot;
    int unsigned      hold;
    int unsigned      bounce;
    int unsigned      rel;
    maint = ($urandom_range(0, 3) == 0);
    rpt = 1'($urandom_range(0, 1));
    run = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 3) != 0) begin
      slot = $urandom_range(0, 9);
      if (slot > 7) slot = slot + 2;
      press = '0;
      press[slot] = 1'b1;
    end else begin
      press = key_vec_t'($urandom) & SCANNED_KEYS;
    end
    hold = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 24);
    bounce = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    rel = $urandom_range(0, 14);

    for (int i = 0; i < hold + rel; i++) begin
      keys = (i < hold) ? press : '0;
      if (i < bounce) keys = keys ^ (key_vec_t'($urandom) & SCANNED_KEYS);
      r2 = ROW_W'($urandom);
      r2[K_DEP_NEXT] = keys[K_DEP_NEXT];
      r2[K_DEP_THIS] = keys[K_DEP_THIS];
      r2[R2_MAINT] = maint;
      r2[R2_REPEAT] = rpt;
      r4 = ROW_W'($urandom);
      r4[7:0] = keys[7:0];
      queue_scan(r2, pick_row_three(), r4, run);
    end
  endtask

  task automatic build_scans();
    // Maintenance: readin, continue, stop and examine-this held until they fire.
    for (int i = 0; i < 10; i++) queue_scan(16'hF3FF, 16'hFFFF, 16'hFFB2, 1'b1);
    // Running, repeat on: execute, reset, both deposit keys; the others let go.
    for (int i = 0; i < 10; i++) queue_scan(16'h0C20, 16'h0000, 16'h000C, 1'b1);
    queue_scan(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);
    queue_scan(16'h5555, 16'hAAAA, 16'h5555, 1'b1);
    queue_scan(16'h0000, 16'h0000, 16'h0000, 1'b0);

    while (scans_to_send.size() < SCAN_TARGET) begin
      if ($urandom_range(0, 11) == 0) begin
        // raw noise, including broken presses and mode flips
        repeat ($urandom_range(1, 4))
          queue_scan(ROW_W'($urandom), ROW_W'($urandom), ROW_W'($urandom),
                     1'($urandom_range(0, 1)));
      end else begin
        add_press_episode();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued scans, predicts each accepted transaction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        accepted_scan.row_two = in_row_two_bits;
        accepted_scan.row_three = in_row_three_bits;
        accepted_scan.row_four = in_row_four_bits;
        accepted_scan.running = in_cpu_running;
        awaited_panel_outputs.push_back(debounce_and_dispatch(accepted_scan));
        scans_accepted++;
      end
      // payload may only move when nothing is being offered or it just went
      if (!in_valid || in_ready) begin
        if (send_gap == 0 && idling_allowed() && $urandom_range(0, 7) == 0)
          send_gap = $urandom_range(1, 5);
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (scans_to_send.size() != 0) begin
          next_scan = scans_to_send.pop_front();
          in_valid <= 1'b1;
          in_row_two_bits <= next_scan.row_two;
          in_row_three_bits <= next_scan.row_three;
          in_row_four_bits <= next_scan.row_four;
          in_cpu_running <= next_scan.running;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result transaction against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen_out = {out_examine_pulse, out_execute_pulse, out_stop_pulse, out_deposit_pulse,
                    out_power_off_pulse, out_clear_indicator, out_address_latched,
                    out_readin_device, out_repeat_rate, out_indicator_disabled,
                    out_pending_keys, out_mode_bits};
        if (awaited_panel_outputs.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("result %0d with nothing outstanding: %s", results_seen,
                     show_panel(seen_out));
        end else begin
          want_out = awaited_panel_outputs.pop_front();
          if (seen_out !== want_out) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT) begin
              $display("result %0d mismatch", results_seen);
              $display("  expected %s", show_panel(want_out));
              $display("  actual   %s", show_panel(seen_out));
            end
          end
        end
        results_seen++;
      end

      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap--;
        out_ready <= 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 4);  // ready drops now and stays low while sink_gap counts down
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Long result-side stall: the output register fills and in_ready drops.
  initial begin
    while (scans_accepted < HOLD_OFF_AT) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_LEN) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog: too long without any transaction on either side.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: %0d scans accepted, %0d results, %0d outstanding",
             scans_accepted, results_seen, awaited_panel_outputs.size());
    $display("FAIL panel_switch_debounce_dispatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    build_scans();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (scans_to_send.size() != 0 || in_valid) @(posedge clk);
    while (awaited_panel_outputs.size() != 0) @(posedge clk);
    // anything arriving now is an extra result and gets flagged by the monitor
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0) begin
      $display("PASS panel_switch_debounce_dispatch");
    end else begin
      $display("%0d failing results", fault_count);
      $display("FAIL panel_switch_debounce_dispatch");
    end
    $finish;
  end

endmodule
